@@ rtl/core/can_log_record_parser_defines.svh @@
// Assertion macros shared by the CAN log record parser RTL.
// Included by clp_emitter, the module that carries concurrent assertions; no other dependencies.
`ifndef CAN_LOG_RECORD_PARSER_DEFINES_SVH
`define CAN_LOG_RECORD_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising edge outside reset.
`define CLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define CLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/clp_pkg.sv @@
// Types and constants of the CAN log record parser.
// No dependencies; imported by clp_field_parser, clp_emitter, the top level and the testbench.
package clp_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int LEN_CLAMP       = 64;
	localparam int CNT_W           = 7;
	localparam int IDX_W           = 6;
	localparam int FLAG_XL_BIT     = 4;
	localparam logic [31:0] MAGIC_VALUE = 32'h4E41434D;

	typedef enum logic [1:0] {
		KIND_FRAME       = 2'd0,
		KIND_SUMMARY_OK  = 2'd1,
		KIND_SUMMARY_BAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] timestamp;
		logic [31:0] frame_id;
		logic [4:0]  flag_bits;
		logic [7:0]  length;
		logic        has_data;
		logic [7:0]  data_byte;
		logic [IDX_W-1:0] byte_index;
		logic        last;
		logic [31:0] frame_count;
	} result_t;

	typedef struct packed {
		logic [63:0] timestamp;
		logic [31:0] frame_id;
		logic [4:0]  flag_bits;
		logic [7:0]  length;
	} frame_desc_t;

	// Parser to emitter: one frame or summary to put out.
	typedef struct packed {
		logic             frame;
		logic             summary;
		kind_t            kind;
		logic [31:0]      total;
		logic [CNT_W-1:0] count;
		frame_desc_t      desc;
	} emit_cmd_t;

endpackage

@@ rtl/core/clp_stream_if.sv @@
// Valid/ready stream channel carrying one word of type payload_t.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface clp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/clp_payload_ram.sv @@
// Payload buffer of the CAN log record parser: one write port, one registered read port.
// Depends on nothing but its parameters.
module clp_payload_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ rtl/core/clp_field_parser.sv @@
// Byte-level record parser: header check, field assembly, payload writes, frame count.
// Depends on clp_pkg; feeds clp_payload_ram and clp_emitter.
module clp_field_parser #(
	parameter int MAX_PAYLOAD = clp_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = $clog2(MAX_PAYLOAD)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  clp_pkg::in_item_t   item,
	output clp_pkg::emit_cmd_t  cmd,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [7:0]          wr_data
);
	import clp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_STAMP,
		PH_IDENT,
		PH_FLAGS,
		PH_LENGTH,
		PH_DATA,
		PH_DEAD
	} phase_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

	phase_t           phase_q;
	logic [3:0]       fb_q;
	logic [31:0]      magic_q;
	logic [63:0]      stamp_q;
	logic [31:0]      ident_q;
	logic [4:0]       flags_q;
	logic [7:0]       len_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] taken_q;
	logic [31:0]      total_q;

	logic [7:0]       b;
	logic             eos;
	logic             xl;
	logic [15:0]      len_full;
	logic [7:0]       len_final;
	logic [CNT_W-1:0] cnt_final;
	logic             len_done;
	logic             data_done;
	logic             frame_done;
	logic             bad;
	logic [CNT_W-1:0] emit_cnt;

	assign b        = item.byte_value;
	assign eos      = item.end_of_stream;
	assign xl       = flags_q[FLAG_XL_BIT];
	assign len_full = {b, len_q};

	always_comb begin
		if (xl) begin
			len_final = (len_full > 16'(LEN_CLAMP)) ? 8'(LEN_CLAMP) : len_q;
		end else begin
			len_final = b;
		end
		cnt_final = (len_final >= 8'(LEN_CLAMP)) ? CNT_W'(LEN_CLAMP) : len_final[CNT_W-1:0];
	end

	assign len_done   = (phase_q == PH_LENGTH) && (!xl || fb_q[0]);
	assign data_done  = (phase_q == PH_DATA) && ((taken_q + CNT_W'(1)) == cnt_q);
	assign frame_done = accept && !eos && ((len_done && cnt_final == '0) || data_done);
	assign bad        = (phase_q == PH_DEAD) || (phase_q == PH_HEADER && fb_q < 4'd4);
	assign emit_cnt   = (phase_q != PH_DATA) ? '0 : ((cnt_q < MAX_CNT) ? cnt_q : MAX_CNT);

	always_comb begin
		cmd.frame          = frame_done;
		cmd.summary        = accept && eos;
		cmd.kind           = bad ? KIND_SUMMARY_BAD : KIND_SUMMARY_OK;
		cmd.total          = bad ? 32'd0 : total_q;
		cmd.count          = emit_cnt;
		cmd.desc.timestamp = stamp_q;
		cmd.desc.frame_id  = ident_q;
		cmd.desc.flag_bits = flags_q;
		cmd.desc.length    = (phase_q == PH_DATA) ? len_q : len_final;
	end

	// Buffer only the first MAX_PAYLOAD data bytes; the rest are consumed and dropped.
	assign wr_en   = accept && !eos && (phase_q == PH_DATA) && (taken_q < MAX_CNT);
	assign wr_addr = taken_q[AW-1:0];
	assign wr_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			fb_q    <= '0;
			magic_q <= '0;
			stamp_q <= '0;
			ident_q <= '0;
			flags_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			taken_q <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (eos) begin
				phase_q <= PH_HEADER;
				fb_q    <= '0;
				magic_q <= '0;
				taken_q <= '0;
				total_q <= '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (fb_q < 4'd4) begin
							magic_q[{fb_q[1:0], 3'b000} +: 8] <= b;
						end
						fb_q <= fb_q + 4'd1;
						if (fb_q == 4'd3 && {b, magic_q[23:0]} != MAGIC_VALUE) begin
							phase_q <= PH_DEAD;
						end else if (fb_q == 4'd7) begin
							phase_q <= PH_STAMP;
							fb_q    <= '0;
						end
					end
					PH_STAMP: begin
						stamp_q[{fb_q[2:0], 3'b000} +: 8] <= b;
						if (fb_q == 4'd7) begin
							phase_q <= PH_IDENT;
							fb_q    <= '0;
						end else begin
							fb_q <= fb_q + 4'd1;
						end
					end
					PH_IDENT: begin
						ident_q[{fb_q[1:0], 3'b000} +: 8] <= b;
						if (fb_q == 4'd3) begin
							phase_q <= PH_FLAGS;
							fb_q    <= '0;
						end else begin
							fb_q <= fb_q + 4'd1;
						end
					end
					PH_FLAGS: begin
						flags_q <= b[4:0];
						phase_q <= PH_LENGTH;
						fb_q    <= '0;
					end
					PH_LENGTH: begin
						if (!len_done) begin
							len_q <= b;
							fb_q  <= 4'd1;
						end else begin
							len_q   <= len_final;
							cnt_q   <= cnt_final;
							fb_q    <= '0;
							taken_q <= '0;
							if (cnt_final == '0) begin
								phase_q <= PH_STAMP;
								if (total_q != '1) begin
									total_q <= total_q + 32'd1;
								end
							end else begin
								phase_q <= PH_DATA;
							end
						end
					end
					PH_DATA: begin
						if (data_done) begin
							phase_q <= PH_STAMP;
							fb_q    <= '0;
							taken_q <= '0;
							if (total_q != '1) begin
								total_q <= total_q + 32'd1;
							end
						end else begin
							taken_q <= taken_q + CNT_W'(1);
						end
					end
					PH_DEAD: begin
						phase_q <= PH_DEAD;
					end
					default: begin
						phase_q <= PH_DEAD;
					end
				endcase
			end
		end
	end
endmodule

@@ rtl/core/clp_emitter.sv @@
// Result emitter: drains the payload buffer into the output register; also sends summaries.
// Depends on clp_pkg, clp_stream_if and can_log_record_parser_defines.svh.
`include "can_log_record_parser_defines.svh"

module clp_emitter #(
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clp_pkg::emit_cmd_t cmd,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data,
	output logic               take_ok,
	clp_stream_if.source       records
);
	import clp_pkg::*;

	logic [CNT_W-1:0] e_q;
	logic [CNT_W-1:0] issue_q;
	logic             s1_valid_s1;
	logic [CNT_W-1:0] s1_idx_s1;
	frame_desc_t      desc_q;
	logic             out_valid_q;
	result_t          out_q;

	logic slot_free;
	logic pending;
	logic load_s1;
	logic s1_last;
	logic idle;
	logic start_run;
	logic start_zero;

	assign slot_free  = !out_valid_q || records.ready;
	assign pending    = (issue_q != e_q);
	assign idle       = !pending && !s1_valid_s1;
	assign rd_en      = pending && (!s1_valid_s1 || slot_free);
	assign rd_addr    = issue_q[AW-1:0];
	assign load_s1    = s1_valid_s1 && slot_free;
	assign s1_last    = ((s1_idx_s1 + CNT_W'(1)) == e_q);
	assign start_run  = cmd.frame && (cmd.count != '0);
	assign start_zero = cmd.frame && (cmd.count == '0);
	assign take_ok    = idle && slot_free;

	assign records.valid   = out_valid_q;
	assign records.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q         <= '0;
			issue_q     <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_run) begin
				e_q     <= cmd.count;
				issue_q <= '0;
			end else if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end

			if (rd_en) begin
				s1_valid_s1 <= 1'b1;
			end else if (load_s1) begin
				s1_valid_s1 <= 1'b0;
			end

			if (load_s1 || start_zero || cmd.summary) begin
				out_valid_q <= 1'b1;
			end else if (records.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_run) begin
			desc_q <= cmd.desc;
		end
		if (rd_en) begin
			s1_idx_s1 <= issue_q;
		end
		if (load_s1) begin
			out_q.kind        <= KIND_FRAME;
			out_q.timestamp   <= desc_q.timestamp;
			out_q.frame_id    <= desc_q.frame_id;
			out_q.flag_bits   <= desc_q.flag_bits;
			out_q.length      <= desc_q.length;
			out_q.has_data    <= 1'b1;
			out_q.data_byte   <= rd_data;
			out_q.byte_index  <= s1_idx_s1[IDX_W-1:0];
			out_q.last        <= s1_last;
			out_q.frame_count <= '0;
		end else if (start_zero) begin
			out_q.kind        <= KIND_FRAME;
			out_q.timestamp   <= cmd.desc.timestamp;
			out_q.frame_id    <= cmd.desc.frame_id;
			out_q.flag_bits   <= cmd.desc.flag_bits;
			out_q.length      <= cmd.desc.length;
			out_q.has_data    <= 1'b0;
			out_q.data_byte   <= '0;
			out_q.byte_index  <= '0;
			out_q.last        <= 1'b1;
			out_q.frame_count <= '0;
		end else if (cmd.summary) begin
			out_q.kind        <= cmd.kind;
			out_q.timestamp   <= '0;
			out_q.frame_id    <= '0;
			out_q.flag_bits   <= '0;
			out_q.length      <= '0;
			out_q.has_data    <= 1'b0;
			out_q.data_byte   <= '0;
			out_q.byte_index  <= '0;
			out_q.last        <= 1'b1;
			out_q.frame_count <= cmd.total;
		end
	end

	`CLP_ASSERT(a_start_when_idle, clk, arst_n, (cmd.frame || cmd.summary) |-> (idle && slot_free), "run started while emitter busy")
	`CLP_ASSERT(a_issue_bound, clk, arst_n, issue_q <= e_q, "read pointer ran past frame length")
	`CLP_ASSERT(a_s1_in_range, clk, arst_n, s1_valid_s1 |-> (s1_idx_s1 < e_q), "read stage holds index beyond run")
	`CLP_ASSERT(a_drain_to_idle, clk, arst_n, (load_s1 && s1_last) |=> idle, "emitter not idle after final result")
	`CLP_ASSERT_ALWAYS(a_reset_clears_out, clk, !arst_n |=> !out_valid_q, "output valid after a reset edge")
endmodule

@@ rtl/core/can_log_record_parser.sv @@
// Top level of the CAN log record parser: byte channel in, result channel out.
// Depends on clp_pkg, clp_stream_if, clp_field_parser, clp_payload_ram and clp_emitter.
//
// The block reads a CAN log file one byte per word on the bytes channel and
// puts out frame results and end summaries on the records channel. The file
// opens with an 8-byte header whose first four bytes (little endian) must be
// the magic word 0x4E41434D; the next four are skipped. Each record then
// carries an 8-byte timestamp, a 4-byte identifier, a flags byte and a length
// (two bytes, clamped to 64, when the XL flag is set, otherwise one byte),
// followed by min(length,64) data bytes. The first MAX_PAYLOAD data bytes go
// into an on-chip payload buffer. When the last byte of a record arrives, the
// record is put out as one result per buffered byte (or a single result with
// has_data low when nothing was buffered), with last high on the final one.
// A word with end_of_stream set yields one summary: kind ok with the frame
// count (saturating), or kind bad header with a zero count when the magic was
// wrong or never completed; the parser then re-arms for a new file. A record
// cut short by end of stream is dropped silently.
// Rate: a record that puts out e buffered bytes keeps the bytes channel
// stalled while it drains through the payload buffer's single read port,
// one result per cycle while the records channel is ready; input resumes
// once the final result sits in the output register. A stalled records
// channel holds the input off. No clearing pass is needed after reset:
// buffer entries are only read after being written within the same record.
module can_log_record_parser #(
	parameter int MAX_PAYLOAD = clp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	clp_stream_if.sink   bytes,
	clp_stream_if.source records
);
	import clp_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);

	emit_cmd_t     cmd;
	logic          accept;
	logic          take_ok;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// Take a byte only when the emitter has nothing left to drain and the
	// output register can accept whatever this byte might produce.
	assign bytes.ready = take_ok;
	assign accept      = bytes.valid && take_ok;

	clp_field_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (bytes.payload),
		.cmd     (cmd),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Payload buffer: written by the parser during the data bytes of a
	// record, read back by the emitter after the record completes.
	clp_payload_ram #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	clp_emitter #(
		.AW (AW)
	) u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.take_ok (take_ok),
		.records (records)
	);
endmodule

@@ verif/tb.sv @@
// Self-checking testbench for can_log_record_parser: feeds log files byte by byte
// and checks every frame result and end summary against a behavioral parser model or the directed table.
// Depends on clp_pkg, clp_stream_if and the can_log_record_parser RTL.
module tb;
	import clp_pkg::*;

	localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF;
	localparam int FEED_WORDS  = 310;
	localparam int PRINT_CAP   = 40;

	// Parser phases, in file order.
	typedef enum logic [2:0] {
		PS_HEADER,
		PS_STAMP,
		PS_IDENT,
		PS_FLAGS,
		PS_LENGTH,
		PS_DATA,
		PS_DEAD
	} parse_phase_t;

	// One row of the directed table: the word to send and, where it is obvious,
	// the result it must produce.
	typedef struct {
		in_item_t word;
		logic     typed;
		result_t  want;
	} step_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	in_item_t src_word = '0;
	logic     sink_ready = 1'b0;

	int unsigned sender_idle_pct = 21;
	int unsigned sink_idle_pct = 56;
	int unsigned error_count = 0;
	int unsigned bytes_fed = 0;

	result_t    records_due[$];
	result_t    produced[$];
	logic [7:0] record_bytes[$];
	step_row_t  directed_rows[$];

	// Parser model state
	parse_phase_t parse_st;
	int unsigned  field_cnt;
	logic [31:0]  magic_acc;
	logic [63:0]  stamp_acc;
	logic [31:0]  id_acc;
	logic [4:0]   flag_reg;
	logic [15:0]  len_reg;
	logic [7:0]   payload_buf [PAYLOAD_CAP];
	int unsigned  data_taken;
	logic [31:0]  frames_seen;
	logic         magic_bad;

	clp_stream_if #(.payload_t(in_item_t)) bytes_ch ();
	clp_stream_if #(.payload_t(result_t)) records_ch ();

	assign bytes_ch.valid   = src_valid;
	assign bytes_ch.payload = src_word;
	assign records_ch.ready = sink_ready;

	can_log_record_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_ch),
		.records(records_ch)
	);

	always #4 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_CAP)
			$display("ERROR at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic clear_parser();
		parse_st    = PS_HEADER;
		field_cnt   = 0;
		magic_acc   = '0;
		stamp_acc   = '0;
		id_acc      = '0;
		flag_reg    = '0;
		len_reg     = '0;
		data_taken  = 0;
		frames_seen = '0;
		magic_bad   = 1'b0;
	endtask

	function automatic int unsigned data_bytes_due();
		return (len_reg < LEN_CLAMP) ? int'(len_reg) : LEN_CLAMP;
	endfunction

	// Put out the finished record: one result per buffered byte, or a single
	// empty result when nothing was buffered.
	task automatic put_out_frame();
		int unsigned kept;
		int unsigned runs;
		result_t r;
		kept = data_bytes_due();
		if (kept > PAYLOAD_CAP)
			kept = PAYLOAD_CAP;
		runs = (kept == 0) ? 1 : kept;
		for (int unsigned k = 0; k < runs; k++) begin
			r = '0;
			r.kind       = KIND_FRAME;
			r.timestamp  = stamp_acc;
			r.frame_id   = id_acc;
			r.flag_bits  = flag_reg;
			r.length     = len_reg[7:0];
			r.has_data   = (kept != 0);
			r.data_byte  = (kept != 0) ? payload_buf[k] : 8'h00;
			r.byte_index = IDX_W'(k);
			r.last       = (k + 1 == runs);
			produced.push_back(r);
		end
		if (frames_seen != 32'hFFFF_FFFF)
			frames_seen++;
		parse_st   = PS_STAMP;
		field_cnt  = 0;
		data_taken = 0;
	endtask

	// Advance the parser model by one accepted word; results land in produced.
	task automatic parse_byte_word(input in_item_t w);
		logic [7:0] b;
		logic       bad;
		result_t    r;
		b = w.byte_value;
		if (w.end_of_stream) begin
			bad = magic_bad || (parse_st == PS_HEADER && field_cnt < 4);
			r = '0;
			r.kind        = bad ? KIND_SUMMARY_BAD : KIND_SUMMARY_OK;
			r.last        = 1'b1;
			r.frame_count = bad ? 32'd0 : frames_seen;
			produced.push_back(r);
			clear_parser();
			return;
		end
		case (parse_st)
			PS_HEADER: begin
				if (field_cnt < 4)
					magic_acc |= 32'(b) << (8 * field_cnt);
				field_cnt++;
				if (field_cnt == 4 && magic_acc != MAGIC_VALUE) begin
					magic_bad = 1'b1;
					parse_st  = PS_DEAD;
				end else if (field_cnt >= 8) begin
					parse_st  = PS_STAMP;
					field_cnt = 0;
				end
			end
			PS_STAMP: begin
				if (field_cnt == 0)
					stamp_acc = '0;
				stamp_acc |= 64'(b) << (8 * field_cnt);
				field_cnt++;
				if (field_cnt >= 8) begin
					parse_st  = PS_IDENT;
					field_cnt = 0;
				end
			end
			PS_IDENT: begin
				if (field_cnt == 0)
					id_acc = '0;
				id_acc |= 32'(b) << (8 * field_cnt);
				field_cnt++;
				if (field_cnt >= 4) begin
					parse_st  = PS_FLAGS;
					field_cnt = 0;
				end
			end
			PS_FLAGS: begin
				flag_reg  = b[4:0];
				parse_st  = PS_LENGTH;
				field_cnt = 0;
				len_reg   = '0;
			end
			PS_LENGTH: begin
				len_reg |= 16'(b) << (8 * (field_cnt & 1));
				field_cnt++;
				// XL form takes a second length byte and is clamped.
				if (!(flag_reg[FLAG_XL_BIT] && field_cnt < 2)) begin
					if (flag_reg[FLAG_XL_BIT] && len_reg > LEN_CLAMP)
						len_reg = 16'(LEN_CLAMP);
					field_cnt  = 0;
					data_taken = 0;
					if (data_bytes_due() == 0)
						put_out_frame();
					else
						parse_st = PS_DATA;
				end
			end
			PS_DATA: begin
				if (data_taken < PAYLOAD_CAP)
					payload_buf[data_taken] = b;
				data_taken++;
				if (data_taken >= data_bytes_due())
					put_out_frame();
			end
			default: ;
		endcase
	endtask

	// Offer one word, wait for the handshake, then queue what it must produce.
	// A typed row replaces the model's result with the one written in the table.
	task automatic send_word(input in_item_t w, input logic typed, input result_t want);
		logic ignored;
		while ($urandom_range(99) < sender_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= w;
		@(posedge clk);
		while (bytes_ch.ready !== 1'b1)
			@(posedge clk);
		ignored = (parse_st == PS_DEAD) && !w.end_of_stream;
		produced.delete();
		parse_byte_word(w);
		if (typed)
			records_due.push_back(want);
		else
			foreach (produced[i])
				records_due.push_back(produced[i]);
		if (!ignored)
			bytes_fed++;
	endtask

	function automatic step_row_t feed(input logic [7:0] b);
		step_row_t r;
		r.word.byte_value    = b;
		r.word.end_of_stream = 1'b0;
		r.typed              = 1'b0;
		r.want               = '0;
		return r;
	endfunction

	function automatic step_row_t close_file(input kind_t k, input logic [31:0] cnt);
		step_row_t r;
		r.word.byte_value    = 8'hA5;
		r.word.end_of_stream = 1'b1;
		r.typed              = 1'b1;
		r.want               = '0;
		r.want.kind          = k;
		r.want.last          = 1'b1;
		r.want.frame_count   = cnt;
		return r;
	endfunction

	// Fill record_bytes with one well-formed record with random content.
	// Mostly short payloads; now and then the full 64 bytes or a clamped length.
	task automatic build_record();
		logic [63:0] ts;
		logic [31:0] id;
		logic [7:0]  fl;
		logic [15:0] len;
		int unsigned n;
		int unsigned pick;
		record_bytes.delete();
		pick = $urandom_range(9);
		ts = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : {$urandom, $urandom};
		pick = $urandom_range(9);
		id = (pick == 0) ? 32'd0 : (pick == 1) ? '1 : $urandom;
		fl = 8'($urandom);
		fl[FLAG_XL_BIT] = ($urandom_range(9) < 4);
		pick = $urandom_range(99);
		if (fl[FLAG_XL_BIT]) begin
			if (pick < 70)
				len = 16'($urandom_range(12));
			else if (pick < 85)
				len = 16'($urandom_range(64, 13));
			else if (pick < 95)
				len = 16'($urandom_range(65535, 65));
			else
				len = 16'hFFFF;
		end else begin
			if (pick < 75)
				len = 16'($urandom_range(12));
			else if (pick < 90)
				len = 16'($urandom_range(64, 13));
			else
				len = 16'($urandom_range(255, 65));
		end
		n = (len < LEN_CLAMP) ? int'(len) : LEN_CLAMP;
		for (int i = 0; i < 8; i++)
			record_bytes.push_back(ts[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			record_bytes.push_back(id[8*i +: 8]);
		record_bytes.push_back(fl);
		record_bytes.push_back(len[7:0]);
		if (fl[FLAG_XL_BIT])
			record_bytes.push_back(len[15:8]);
		for (int unsigned i = 0; i < n; i++)
			record_bytes.push_back(8'($urandom));
	endtask

	// One whole file: mostly a good header and records, sometimes a short or
	// corrupt header, a file that stops in the version word, or a cut record.
	task automatic send_file();
		int unsigned pick;
		int unsigned n_magic;
		int unsigned n_vers;
		int unsigned cut;
		logic [31:0] magic;
		pick    = $urandom_range(99);
		magic   = MAGIC_VALUE;
		n_magic = (pick < 6) ? $urandom_range(3) : 4;
		if (pick >= 6 && pick < 12)
			magic ^= 32'($urandom_range(255, 1)) << (8 * $urandom_range(3));
		for (int unsigned i = 0; i < n_magic; i++)
			send_word({magic[8*i +: 8], 1'b0}, 1'b0, '0);
		if (pick >= 6 && pick < 12) begin
			// Corrupt magic: trailing bytes must be dropped.
			repeat ($urandom_range(5))
				send_word({8'($urandom), 1'b0}, 1'b0, '0);
		end else if (pick >= 12) begin
			n_vers = (pick < 16) ? $urandom_range(3) : 4;
			repeat (n_vers)
				send_word({8'($urandom), 1'b0}, 1'b0, '0);
			if (n_vers == 4) begin
				repeat ($urandom_range(4, 1)) begin
					build_record();
					foreach (record_bytes[i])
						send_word({record_bytes[i], 1'b0}, 1'b0, '0);
				end
				if ($urandom_range(3) == 0) begin
					build_record();
					cut = $urandom_range(record_bytes.size() - 1, 1);
					for (int unsigned i = 0; i < cut; i++)
						send_word({record_bytes[i], 1'b0}, 1'b0, '0);
				end
			end
		end
		send_word({8'($urandom), 1'b1}, 1'b0, '0);
	endtask

	// Receiver side: stall at random at the current rate.
	always @(posedge clk)
		sink_ready <= ($urandom_range(99) >= sink_idle_pct);

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && records_ch.valid === 1'b1 && records_ch.ready === 1'b1) begin
			got = records_ch.payload;
			if (records_due.size() == 0) begin
				report_mismatch("result with nothing expected, kind", 64'(got.kind), 64'd0);
			end else begin
				want = records_due.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", 64'(got.kind), 64'(want.kind));
				if (got.timestamp !== want.timestamp)
					report_mismatch("timestamp", got.timestamp, want.timestamp);
				if (got.frame_id !== want.frame_id)
					report_mismatch("frame_id", 64'(got.frame_id), 64'(want.frame_id));
				if (got.flag_bits !== want.flag_bits)
					report_mismatch("flag_bits", 64'(got.flag_bits), 64'(want.flag_bits));
				if (got.length !== want.length)
					report_mismatch("length", 64'(got.length), 64'(want.length));
				if (got.has_data !== want.has_data)
					report_mismatch("has_data", 64'(got.has_data), 64'(want.has_data));
				if (got.data_byte !== want.data_byte)
					report_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
				if (got.byte_index !== want.byte_index)
					report_mismatch("byte_index", 64'(got.byte_index), 64'(want.byte_index));
				if (got.last !== want.last)
					report_mismatch("last", 64'(got.last), 64'(want.last));
				if (got.frame_count !== want.frame_count)
					report_mismatch("frame_count", 64'(got.frame_count), 64'(want.frame_count));
			end
		end
	end

	initial begin
		int unsigned guard;
		// Header corner cases: empty stream, magic cut short, corrupt magic
		// with a dropped trailing byte, stream ending in the version word,
		// and a record cut off in its timestamp.
		directed_rows = '{
			close_file(KIND_SUMMARY_BAD, 32'd0),
			feed(8'h4D), feed(8'h43), feed(8'h41),
			close_file(KIND_SUMMARY_BAD, 32'd0),
			feed(8'h4D), feed(8'h43), feed(8'h41), feed(8'hCE), feed(8'hFF),
			close_file(KIND_SUMMARY_BAD, 32'd0),
			feed(8'h4D), feed(8'h43), feed(8'h41), feed(8'h4E), feed(8'hFF),
			close_file(KIND_SUMMARY_OK, 32'd0),
			feed(8'h4D), feed(8'h43), feed(8'h41), feed(8'h4E),
			feed(8'h00), feed(8'hFF), feed(8'h00), feed(8'hFF),
			feed(8'hFF), feed(8'h00),
			close_file(KIND_SUMMARY_OK, 32'd0)
		};
		clear_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

		// Random files; swap the idle rates after a third, then stop idling.
		bytes_fed = 0;
		while (bytes_fed < FEED_WORDS) begin
			if (bytes_fed >= 2 * FEED_WORDS / 3) begin
				sender_idle_pct = 0;
				sink_idle_pct   = 0;
			end else if (bytes_fed >= FEED_WORDS / 3) begin
				sender_idle_pct = 56;
				sink_idle_pct   = 21;
			end
			send_file();
		end
		src_valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		guard = 0;
		while (records_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
		if (records_due.size() != 0)
			report_mismatch("results never seen", 64'(records_due.size()), 64'd0);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/clp_pkg.sv
rtl/core/clp_stream_if.sv
rtl/core/clp_payload_ram.sv
rtl/core/clp_field_parser.sv
rtl/core/clp_emitter.sv
rtl/core/can_log_record_parser.sv
verif/tb.sv
